// ===== hw/rtl/lcfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcfs_pkg: shared types and constants of the LED color fade smoother
// Holds command codes, register indexes, reset values, the rotation counter
// constants and the slot routing function used by several files.
// ----------------------------------------------------------------------------
package lcfs_pkg;

    // Value and layout constants.
    localparam int VALUE_BITS_DEF = 16;
    localparam int SLOTS          = 4;
    localparam int NUM_VALUES     = 8;
    localparam int SLOT_BITS      = 2;
    localparam int INDEX_BITS     = 3;

    // Configuration register widths and reset values.
    localparam int SHIFT_BITS     = 3;
    localparam int ALPHA_BITS     = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam logic [SHIFT_BITS-1:0] SHIFT_RESET     = 3'd3;
    localparam logic [ALPHA_BITS-1:0] ALPHA_MIN_RESET = 16'd819;
    localparam logic [ALPHA_BITS-1:0] ALPHA_MAX_RESET = 16'd18022;

    // Rotation counter in thousandths, wrapping at three.
    localparam int COUNTER_BITS = 12;
    localparam logic [COUNTER_BITS-1:0] COUNTER_STEP  = 12'd7;
    localparam logic [COUNTER_BITS-1:0] COUNTER_WRAP  = 12'd3000;
    localparam logic [COUNTER_BITS-1:0] COUNTER_ONE   = 12'd1000;
    localparam logic [COUNTER_BITS-1:0] COUNTER_TWO   = 12'd2000;

    // Rotation codes and the alpha slot.
    localparam logic [SLOT_BITS-1:0] ROT_ZERO   = 2'd0;
    localparam logic [SLOT_BITS-1:0] ROT_ONE    = 2'd1;
    localparam logic [SLOT_BITS-1:0] ROT_TWO    = 2'd2;
    localparam logic [SLOT_BITS-1:0] SLOT_RED   = 2'd0;
    localparam logic [SLOT_BITS-1:0] SLOT_GREEN = 2'd1;
    localparam logic [SLOT_BITS-1:0] SLOT_BLUE  = 2'd2;
    localparam logic [SLOT_BITS-1:0] SLOT_ALPHA = 2'd3;

    // Item kinds.
    typedef enum logic {
        CMD_SET  = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SMOOTH_SHIFT = 2'd0,
        CFG_ALPHA_MIN    = 2'd1,
        CFG_ALPHA_MAX    = 2'd2
    } cfg_reg_t;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [SHIFT_BITS-1:0] smooth_shift;
        logic [ALPHA_BITS-1:0] alpha_min;
        logic [ALPHA_BITS-1:0] alpha_max;
    } cfg_t;

    // Target slot that drives a current slot: target i drives slot
    // (i + rot) mod 3, so slot s follows target (s - rot) mod 3.
    // Alpha always follows alpha.
    function automatic logic [SLOT_BITS-1:0] slot_source(
        input logic [SLOT_BITS-1:0] slot,
        input logic [SLOT_BITS-1:0] rot
    );
        logic [SLOT_BITS-1:0] src;
        src = slot;
        if (slot != SLOT_ALPHA)
        begin
            unique case (rot)
                ROT_ONE:
                begin
                    unique case (slot)
                        SLOT_RED:   src = SLOT_BLUE;
                        SLOT_GREEN: src = SLOT_RED;
                        default:    src = SLOT_GREEN;
                    endcase
                end
                ROT_TWO:
                begin
                    unique case (slot)
                        SLOT_RED:   src = SLOT_GREEN;
                        SLOT_GREEN: src = SLOT_BLUE;
                        default:    src = SLOT_RED;
                    endcase
                end
                default: src = slot;
            endcase
        end
        return src;
    endfunction

endpackage

// ===== hw/rtl/led_color_fade_smoother.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_color_fade_smoother: two-channel RGBA fade engine
// Set items load clamped targets and advance the color rotation; tick items
// move all eight current components toward their targets and emit them.
//
// Channel  Direction  Transfer contents
// s_*      in         tuser: cmd; tdata: ch0 r,g,b,a then ch1 r,g,b,a
// m_*      out        tdata: out0 r,g,b,a then out1 r,g,b,a
// cfg_*    in         write enable, register index, write data
//
// One item is taken every cycle, save for the stall below; a tick's
// result goes through the input register, then the result register. A
// set yields no result. The current, target and counter registers reset
// to zero, the configuration to its defaults. While a stalled output holds
// a result, set items still pass through the input register; a tick
// waits there and holds off further input until the result is taken.
// ----------------------------------------------------------------------------
module led_color_fade_smoother #(
    parameter int VALUE_BITS = lcfs_pkg::VALUE_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Input stream.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic                                   s_tuser,   // [0] cmd
    // ch0_red, ch0_green, ch0_blue, ch0_alpha, ch1_red, ch1_green, ch1_blue,
    // ch1_alpha, from the lowest bits up.
    input  logic [lcfs_pkg::NUM_VALUES*VALUE_BITS-1:0] s_tdata,
    // Output stream.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // out0_red, out0_green, out0_blue, out0_alpha, out1_red, out1_green,
    // out1_blue, out1_alpha, from the lowest bits up.
    output logic [lcfs_pkg::NUM_VALUES*VALUE_BITS-1:0] m_tdata,
    // Configuration writes.
    input  logic                                   cfg_we,
    input  logic [lcfs_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [lcfs_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    localparam int NV = lcfs_pkg::NUM_VALUES;

    // Configuration registers.
    lcfs_pkg::cfg_t cfg_reg;

    // Input register.
    logic                          in_valid_reg;
    lcfs_pkg::cmd_t                in_cmd_reg;
    logic [NV-1:0][VALUE_BITS-1:0] in_values_reg;

    // Current colors and result register.
    logic [NV-1:0][VALUE_BITS-1:0] cur_reg;
    logic [NV-1:0][VALUE_BITS-1:0] cur_next;
    logic                          out_valid_reg;
    logic [NV-1:0][VALUE_BITS-1:0] out_data_reg;

    logic [NV-1:0][VALUE_BITS-1:0] targets;
    logic [lcfs_pkg::SLOT_BITS-1:0] rot;
    logic                          in_fire;
    logic                          proc;
    logic                          proc_set;
    logic                          proc_tick;

    // Handshake: the input register moves on when a set can retire or the
    // result register is free or being drained.
    always_comb
    begin
        proc      = in_valid_reg &&
                    ((in_cmd_reg == lcfs_pkg::CMD_SET) || !out_valid_reg || m_tready);
        proc_set  = proc && (in_cmd_reg == lcfs_pkg::CMD_SET);
        proc_tick = proc && (in_cmd_reg == lcfs_pkg::CMD_TICK);
        s_tready  = !in_valid_reg || proc;
        in_fire   = s_tvalid && s_tready;
    end

    // Configuration register writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.smooth_shift <= lcfs_pkg::SHIFT_RESET;
            cfg_reg.alpha_min    <= lcfs_pkg::ALPHA_MIN_RESET;
            cfg_reg.alpha_max    <= lcfs_pkg::ALPHA_MAX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (lcfs_pkg::cfg_reg_t'(cfg_index))
                lcfs_pkg::CFG_SMOOTH_SHIFT:
                    cfg_reg.smooth_shift <= cfg_data[lcfs_pkg::SHIFT_BITS-1:0];
                lcfs_pkg::CFG_ALPHA_MIN:
                    cfg_reg.alpha_min <= cfg_data[lcfs_pkg::ALPHA_BITS-1:0];
                lcfs_pkg::CFG_ALPHA_MAX:
                    cfg_reg.alpha_max <= cfg_data[lcfs_pkg::ALPHA_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proc)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_cmd_reg    <= lcfs_pkg::cmd_t'(s_tuser);
            in_values_reg <= s_tdata;
        end
    end

    // Target colors and rotation.
    lcfs_target_store #(
        .VALUE_BITS (VALUE_BITS)
    ) u_target_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (proc_set),
        .wr_values (in_values_reg),
        .cfg       (cfg_reg),
        .targets   (targets),
        .rot       (rot)
    );

    // One step unit per current slot, each fed by its rotated target.
    for (genvar k = 0; k < NV; k++)
    begin : g_slot
        localparam logic [lcfs_pkg::SLOT_BITS-1:0]  SLOT =
            lcfs_pkg::SLOT_BITS'(k % lcfs_pkg::SLOTS);
        localparam logic [lcfs_pkg::INDEX_BITS-1:0] BASE =
            lcfs_pkg::INDEX_BITS'((k / lcfs_pkg::SLOTS) * lcfs_pkg::SLOTS);

        logic [lcfs_pkg::INDEX_BITS-1:0] tgt_idx;

        assign tgt_idx = BASE + {1'b0, lcfs_pkg::slot_source(SLOT, rot)};

        lcfs_approach #(
            .VALUE_BITS (VALUE_BITS)
        ) u_approach (
            .cur   (cur_reg[k]),
            .tgt   (targets[tgt_idx]),
            .shift (cfg_reg.smooth_shift),
            .nxt   (cur_next[k])
        );
    end

    // Current colors change only on a tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
        end
        else if (proc_tick)
        begin
            cur_reg <= cur_next;
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_tick)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (proc_tick)
        begin
            out_data_reg <= cur_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Input only stalls while an item waits behind a stalled result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a blocked result");

    // A processed tick always yields a result in the next cycle.
    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        proc_tick |=> m_tvalid)
        else $error("tick processed without a result");

    // A set never creates a result on an empty output.
    a_set_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_set && !m_tvalid) |=> !m_tvalid)
        else $error("set item produced a result");

endmodule

// ===== hw/rtl/lcfs_approach.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcfs_approach: one color component step toward its target
// Seeds a zero component from its target, then moves it by the absolute
// difference shifted right, truncated so it never overshoots.
// ----------------------------------------------------------------------------
module lcfs_approach #(
    parameter int VALUE_BITS = lcfs_pkg::VALUE_BITS_DEF
) (
    input  logic [VALUE_BITS-1:0]           cur,
    input  logic [VALUE_BITS-1:0]           tgt,
    input  logic [lcfs_pkg::SHIFT_BITS-1:0] shift,
    output logic [VALUE_BITS-1:0]           nxt
);

    logic [VALUE_BITS-1:0] seeded;
    logic                  below;
    logic [VALUE_BITS-1:0] diff;
    logic [VALUE_BITS-1:0] step;

    // Seed from the target, then take a truncated fraction of the gap.
    always_comb
    begin
        seeded = (cur == '0) ? tgt : cur;
        below  = (seeded < tgt);
        diff   = below ? (tgt - seeded) : (seeded - tgt);
        step   = diff >> shift;
        nxt    = below ? (seeded + step) : (seeded - step);
    end

endmodule

// ===== hw/rtl/lcfs_target_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcfs_target_store: target colors and rotation counter
// On a set item, clamps both alphas, stores all eight targets and advances
// the thousandths counter by seven modulo 3000; reports the rotation.
// ----------------------------------------------------------------------------
module lcfs_target_store #(
    parameter int VALUE_BITS = lcfs_pkg::VALUE_BITS_DEF
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              wr_en,
    input  logic [lcfs_pkg::NUM_VALUES-1:0][VALUE_BITS-1:0]   wr_values,
    input  lcfs_pkg::cfg_t                                    cfg,
    output logic [lcfs_pkg::NUM_VALUES-1:0][VALUE_BITS-1:0]   targets,
    output logic [lcfs_pkg::SLOT_BITS-1:0]                    rot
);

    localparam int CMP_BITS = (VALUE_BITS > lcfs_pkg::ALPHA_BITS) ?
                              VALUE_BITS : lcfs_pkg::ALPHA_BITS;

    logic [lcfs_pkg::NUM_VALUES-1:0][VALUE_BITS-1:0] target_reg;
    logic [lcfs_pkg::NUM_VALUES-1:0][VALUE_BITS-1:0] target_next;
    logic [lcfs_pkg::COUNTER_BITS-1:0]               counter_reg;
    logic [lcfs_pkg::COUNTER_BITS-1:0]               counter_next;
    logic [lcfs_pkg::COUNTER_BITS-1:0]               counter_sum;

    // Lower clamp first, then the upper clamp wins when the two cross.
    function automatic logic [VALUE_BITS-1:0] clamp_alpha(
        input logic [VALUE_BITS-1:0]           a,
        input logic [lcfs_pkg::ALPHA_BITS-1:0] lo,
        input logic [lcfs_pkg::ALPHA_BITS-1:0] hi
    );
        logic [CMP_BITS-1:0] v;
        logic [CMP_BITS-1:0] lo_ext;
        logic [CMP_BITS-1:0] hi_ext;
        v      = CMP_BITS'(a);
        lo_ext = CMP_BITS'(lo);
        hi_ext = CMP_BITS'(hi);
        if (v < lo_ext)
        begin
            v = lo_ext;
        end
        if (v > hi_ext)
        begin
            v = hi_ext;
        end
        return VALUE_BITS'(v);
    endfunction

    // New targets, with both alpha slots clamped.
    always_comb
    begin
        target_next = wr_values;
        target_next[lcfs_pkg::SLOTS - 1] =
            clamp_alpha(wr_values[lcfs_pkg::SLOTS - 1], cfg.alpha_min, cfg.alpha_max);
        target_next[lcfs_pkg::NUM_VALUES - 1] =
            clamp_alpha(wr_values[lcfs_pkg::NUM_VALUES - 1], cfg.alpha_min, cfg.alpha_max);
    end

    // Counter advance with a single compare-and-subtract wrap.
    always_comb
    begin
        counter_sum  = counter_reg + lcfs_pkg::COUNTER_STEP;
        counter_next = (counter_sum >= lcfs_pkg::COUNTER_WRAP) ?
                       (counter_sum - lcfs_pkg::COUNTER_WRAP) : counter_sum;
    end

    // Integer part of the counter selects the rotation.
    always_comb
    begin
        if (counter_reg >= lcfs_pkg::COUNTER_TWO)
        begin
            rot = lcfs_pkg::ROT_TWO;
        end
        else if (counter_reg >= lcfs_pkg::COUNTER_ONE)
        begin
            rot = lcfs_pkg::ROT_ONE;
        end
        else
        begin
            rot = lcfs_pkg::ROT_ZERO;
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg  <= '0;
            counter_reg <= '0;
        end
        else if (wr_en)
        begin
            target_reg  <= target_next;
            counter_reg <= counter_next;
        end
    end

    assign targets = target_reg;

endmodule
